// File: hdl/smre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial mouse report engine package
// Shared types, command codes and constants of the report engine.
// ----------------------------------------------------------------------------
package smre_pkg;

  localparam int RING_DEPTH_DEF  = 256;
  localparam int ACCUM_WIDTH_DEF = 16;

  localparam int ENTRY_W = 19;

  localparam int TX_MAX     = 4;
  localparam int TX_CNT_W   = 3;
  localparam int TXQ_DEPTH  = 8;
  localparam int TXQ_AW     = 3;

  typedef enum logic [1:0] {
    OP_MOVE     = 2'd0,
    OP_SERVICE  = 2'd1,
    OP_TICK     = 2'd2,
    OP_SELFTEST = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_D = 2'd0,
    MODE_R = 2'd1,
    MODE_P = 2'd2,
    MODE_T = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_TAKE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_R = 8'h52;
  localparam logic [7:0] CMD_K = 8'h4B;
  localparam logic [7:0] CMD_L = 8'h4C;
  localparam logic [7:0] CMD_M = 8'h4D;
  localparam logic [7:0] CMD_P = 8'h50;
  localparam logic [7:0] CMD_D = 8'h44;
  localparam logic [7:0] CMD_T = 8'h54;

  localparam logic [1:0] RATE_18MS = 2'd0;
  localparam logic [1:0] RATE_14MS = 2'd1;
  localparam logic [1:0] RATE_9MS  = 2'd2;

  localparam logic [7:0] ST_BYTE0 = 8'hA0;
  localparam logic [7:0] ST_BYTE1 = 8'h02;
  localparam logic [7:0] ST_BYTE2 = 8'h00;

  localparam logic [6:0] MAG_SIG_MASK = 7'h7E;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       fast_baud;
    logic [1:0] rate_code;
  } txe_t;

  typedef struct packed {
    logic [TX_CNT_W-1:0]  count;
    txe_t [TX_MAX-1:0]    entry;
  } txq_push_t;

endpackage : smre_pkg
`default_nettype wire

// File: hdl/smre_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module smre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : smre_ram
`default_nettype wire

// File: hdl/smre_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Report axis unit
// Saturating accumulate of one movement delta and clip to 127 counts.
// ----------------------------------------------------------------------------
module smre_axis #(
  parameter int ACCUM_WIDTH = 16
) (
  input  wire signed [ACCUM_WIDTH-1:0] acc,
  input  wire signed [7:0]             delta,
  input  wire                          add_en,
  output logic signed [ACCUM_WIDTH-1:0] acc_next,
  output logic [6:0]                   mag,
  output logic                         neg
);

  localparam int AW = ACCUM_WIDTH;
  localparam logic signed [AW:0] SUM_HI = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [AW:0] SUM_LO = {2'b11, {(AW-1){1'b0}}};
  localparam logic signed [AW-1:0] CLIP_POS = AW'(127);
  localparam logic signed [AW-1:0] CLIP_NEG = -CLIP_POS;

  logic signed [AW:0]   sum;
  logic signed [AW-1:0] sat;
  logic signed [AW-1:0] negated;

  always_comb begin
    sum = {acc[AW-1], acc};
    if (add_en) begin
      sum = {acc[AW-1], acc} + {{(AW-7){delta[7]}}, delta};
    end
    if (sum > SUM_HI) begin
      sat = SUM_HI[AW-1:0];
    end else if (sum < SUM_LO) begin
      sat = SUM_LO[AW-1:0];
    end else begin
      sat = sum[AW-1:0];
    end
    negated = -sat;
    if (sat == '0) begin
      acc_next = '0;
      mag      = 7'd0;
      neg      = 1'b0;
    end else if (sat < CLIP_NEG) begin
      acc_next = sat + CLIP_POS;
      mag      = 7'h7f;
      neg      = 1'b1;
    end else if (sat > CLIP_POS) begin
      acc_next = sat - CLIP_POS;
      mag      = 7'h7f;
      neg      = 1'b0;
    end else if (sat[AW-1]) begin
      acc_next = '0;
      mag      = negated[6:0];
      neg      = 1'b1;
    end else begin
      acc_next = '0;
      mag      = sat[6:0];
      neg      = 1'b0;
    end
  end

endmodule : smre_axis
`default_nettype wire

// File: hdl/smre_txq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transmit byte queue
// Takes up to four bytes in one cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module smre_txq (
  input  wire                   clk,
  input  wire                   rst,
  input  smre_pkg::txq_push_t   push,
  output logic                  room,
  output logic                  out_valid,
  input  wire                   out_stall,
  output smre_pkg::txe_t        head
);

  import smre_pkg::*;

  txe_t              mem [TXQ_DEPTH];
  logic [TXQ_AW-1:0] wptr;
  logic [TXQ_AW-1:0] rptr;
  logic [TXQ_AW:0]   count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rptr];
  assign room      = (count <= (TXQ_AW+1)'(TXQ_DEPTH - TX_MAX));

  always_ff @(posedge clk) begin
    for (int i = 0; i < TX_MAX; i++) begin
      if (TX_CNT_W'(i) < push.count) begin
        mem[wptr + TXQ_AW'(i)] <= push.entry[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + TXQ_AW'(push.count);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (TXQ_AW+1)'(push.count) - (TXQ_AW+1)'(pop);
    end
  end

endmodule : smre_txq
`default_nettype wire

// File: hdl/serial_mouse_report_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial mouse report engine
// Device side of a three-byte serial mouse protocol: packet ring, host
// command decode, saturating accumulators and report or self-test bytes.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   operation move_x move_y move_buttons
//                                  rx_valid rx_byte break_seen
//   out      out_valid / out_stall tx_byte last fast_baud rate_code
//
// Each transaction on the input is taken in an accept cycle that issues
// the ring read at the read index; the next cycle works on the registered
// ring data and pushes zero, three or four bytes into an eight-entry queue.
// The input stalls while that cycle runs and while fewer than four queue
// slots are free; the queue hands out one byte per cycle when not stalled.
// Reset clears the indices, accumulators, modes and queue at once; the ring
// memory is not cleared.
// ----------------------------------------------------------------------------
module serial_mouse_report_engine_top #(
  parameter int RING_DEPTH  = smre_pkg::RING_DEPTH_DEF,
  parameter int ACCUM_WIDTH = smre_pkg::ACCUM_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire [1:0]        operation,
  input  wire signed [7:0] move_x,
  input  wire signed [7:0] move_y,
  input  wire [2:0]        move_buttons,
  input  wire              rx_valid,
  input  wire [7:0]        rx_byte,
  input  wire              break_seen,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       tx_byte,
  output logic             last,
  output logic             fast_baud,
  output logic [1:0]       rate_code
);

  import smre_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  state_t                  state;
  op_t                     op;
  logic signed [7:0]       item_x;
  logic signed [7:0]       item_y;
  logic [2:0]              item_btn;
  logic                    item_rxv;
  logic [7:0]              item_rxb;
  logic                    item_brk;

  logic [IW-1:0]           write_index;
  logic [IW-1:0]           read_index;
  logic signed [ACCUM_WIDTH-1:0] accum_x;
  logic signed [ACCUM_WIDTH-1:0] accum_y;
  logic [2:0]              held_buttons;
  mode_t                   report_mode;
  logic [2:0]              prev_buttons;
  logic                    test_done;
  logic                    speed_flag;
  logic [1:0]              interval_code;

  logic [IW-1:0]           write_index_next;
  logic [IW-1:0]           read_index_next;
  logic signed [ACCUM_WIDTH-1:0] accum_x_next;
  logic signed [ACCUM_WIDTH-1:0] accum_y_next;
  logic [2:0]              held_buttons_next;
  mode_t                   report_mode_next;
  logic [2:0]              prev_buttons_next;
  logic                    test_done_next;
  logic                    speed_flag_next;
  logic [1:0]              interval_code_next;

  logic                    accept;
  logic                    room;
  logic                    ring_we;
  logic [ENTRY_W-1:0]      ring_rdata;
  logic [IW-1:0]           wr_inc;
  logic [IW-1:0]           rd_inc;
  logic                    ring_pop;
  logic                    do_report;
  logic                    do_test;
  logic                    force_rep;
  mode_t                   mode_mid;

  logic signed [ACCUM_WIDTH-1:0] ax_next;
  logic signed [ACCUM_WIDTH-1:0] ay_next;
  logic [6:0]              mag_x;
  logic [6:0]              mag_y;
  logic                    neg_x;
  logic                    neg_y;
  logic [2:0]              hdr_btn;
  logic                    significant;
  logic [7:0]              header;

  txq_push_t               push;
  txe_t                    head;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !((state == ST_TAKE) && room);
  assign wr_inc   = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
  assign rd_inc   = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
  assign ring_pop = (read_index != write_index);

  smre_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ring_we),
    .wr_addr(write_index),
    .wr_data({item_btn, item_y, item_x}),
    .rd_addr(read_index),
    .rd_data(ring_rdata)
  );

  smre_axis #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_axis_x (
    .acc     (accum_x),
    .delta   (ring_rdata[7:0]),
    .add_en  (ring_pop),
    .acc_next(ax_next),
    .mag     (mag_x),
    .neg     (neg_x)
  );

  smre_axis #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_axis_y (
    .acc     (accum_y),
    .delta   (ring_rdata[15:8]),
    .add_en  (ring_pop),
    .acc_next(ay_next),
    .mag     (mag_y),
    .neg     (neg_y)
  );

  assign hdr_btn     = ring_pop ? ring_rdata[18:16] : held_buttons;
  assign significant = force_rep || ((mag_x & MAG_SIG_MASK) != '0)
                       || ((mag_y & MAG_SIG_MASK) != '0) || (prev_buttons != hdr_btn);
  assign header      = {significant, 2'b00, (mag_x != '0) && !neg_x,
                        (mag_y != '0) && neg_y, hdr_btn};

  always_comb begin
    write_index_next   = write_index;
    read_index_next    = read_index;
    accum_x_next       = accum_x;
    accum_y_next       = accum_y;
    held_buttons_next  = held_buttons;
    prev_buttons_next  = prev_buttons;
    test_done_next     = test_done;
    speed_flag_next    = speed_flag;
    interval_code_next = interval_code;
    mode_mid           = report_mode;
    ring_we            = 1'b0;
    do_report          = 1'b0;
    do_test            = 1'b0;
    force_rep          = 1'b0;
    push               = '0;

    if (state == ST_EXEC) begin
      case (op)
        OP_MOVE: begin
          if (wr_inc != read_index) begin
            ring_we          = 1'b1;
            write_index_next = wr_inc;
          end
        end
        OP_TICK: begin
          do_report = test_done && (report_mode == MODE_R);
        end
        OP_SELFTEST: begin
          do_test = 1'b1;
        end
        OP_SERVICE: begin
          if (item_brk) begin
            mode_mid = MODE_T;
          end else if (item_rxv && test_done) begin
            case (item_rxb)
              CMD_B: speed_flag_next = 1'b1;
              CMD_R: mode_mid = MODE_R;
              CMD_K: interval_code_next = RATE_18MS;
              CMD_L: interval_code_next = RATE_14MS;
              CMD_M: interval_code_next = speed_flag ? RATE_9MS : RATE_14MS;
              CMD_P: mode_mid = MODE_P;
              CMD_D: mode_mid = MODE_D;
              CMD_T: mode_mid = MODE_T;
              default: ;
            endcase
          end
          if (test_done) begin
            case (mode_mid)
              MODE_P: begin
                mode_mid  = MODE_D;
                do_report = 1'b1;
                force_rep = 1'b1;
              end
              MODE_R: do_report = 1'b1;
              MODE_T: do_test = 1'b1;
              default: ;
            endcase
          end
        end
        default: ;
      endcase

      if (do_report) begin
        accum_x_next      = ax_next;
        accum_y_next      = ay_next;
        held_buttons_next = hdr_btn;
        prev_buttons_next = hdr_btn;
        if (ring_pop) begin
          read_index_next = rd_inc;
        end
        if (significant) begin
          push.count    = TX_CNT_W'(3);
          push.entry[0] = '{tx_byte: header, last: 1'b0,
                            fast_baud: speed_flag_next, rate_code: interval_code_next};
          push.entry[1] = '{tx_byte: {1'b0, mag_x}, last: 1'b0,
                            fast_baud: speed_flag_next, rate_code: interval_code_next};
          push.entry[2] = '{tx_byte: {1'b0, mag_y}, last: 1'b1,
                            fast_baud: speed_flag_next, rate_code: interval_code_next};
        end
      end

      if (do_test) begin
        speed_flag_next   = 1'b0;
        mode_mid          = MODE_D;
        accum_x_next      = '0;
        accum_y_next      = '0;
        prev_buttons_next = '0;
        held_buttons_next = '0;
        test_done_next    = 1'b1;
        push.count        = TX_CNT_W'(TX_MAX);
        push.entry[0] = '{tx_byte: ST_BYTE0, last: 1'b0,
                          fast_baud: 1'b0, rate_code: interval_code_next};
        push.entry[1] = '{tx_byte: ST_BYTE1, last: 1'b0,
                          fast_baud: 1'b0, rate_code: interval_code_next};
        push.entry[2] = '{tx_byte: ST_BYTE2, last: 1'b0,
                          fast_baud: 1'b0, rate_code: interval_code_next};
        push.entry[3] = '{tx_byte: ST_BYTE2, last: 1'b1,
                          fast_baud: 1'b0, rate_code: interval_code_next};
      end
    end
    report_mode_next = mode_mid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= op_t'(operation);
      item_x   <= move_x;
      item_y   <= move_y;
      item_btn <= move_buttons;
      item_rxv <= rx_valid;
      item_rxb <= rx_byte;
      item_brk <= break_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_TAKE;
      write_index   <= '0;
      read_index    <= '0;
      accum_x       <= '0;
      accum_y       <= '0;
      held_buttons  <= '0;
      report_mode   <= MODE_D;
      prev_buttons  <= '0;
      test_done     <= 1'b0;
      speed_flag    <= 1'b0;
      interval_code <= RATE_18MS;
    end else begin
      case (state)
        ST_TAKE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: state <= ST_TAKE;
        default: state <= ST_TAKE;
      endcase
      write_index   <= write_index_next;
      read_index    <= read_index_next;
      accum_x       <= accum_x_next;
      accum_y       <= accum_y_next;
      held_buttons  <= held_buttons_next;
      report_mode   <= report_mode_next;
      prev_buttons  <= prev_buttons_next;
      test_done     <= test_done_next;
      speed_flag    <= speed_flag_next;
      interval_code <= interval_code_next;
    end
  end

  smre_txq u_txq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign tx_byte   = head.tx_byte;
  assign last      = head.last;
  assign fast_baud = head.fast_baud;
  assign rate_code = head.rate_code;

endmodule : serial_mouse_report_engine_top
`default_nettype wire
